// ----- hdl/khm_pkg.sv -----
// ---------------------------------------------------------------------------
// khm_pkg: shared types and codes for the k-way heap merge
// Operation codes, configuration register indexes, datapath command struct.
// ---------------------------------------------------------------------------
`default_nettype none
package khm_pkg;
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_NEXT  = 2'd2;
   localparam logic [1:0] OP_EXH   = 2'd3;

   localparam int REG_COLS = 0;
   localparam int REG_ASC  = 1;

   typedef struct packed {
      logic put;       // write request row at slot heap_size, size++
      logic put_run;   // use popped run instead of request run
      logic scan_init; // scan index <= 0
      logic scan_step; // compare fetched candidate against best
      logic fetch;     // register entry at scan index
      logic emit;      // load output from best, start fill move
      logic move;      // copy last entry into best slot
      logic done;      // load done result
   } cmd_type;

   typedef struct packed {
      logic       full;
      logic       empty;
      logic       scan_end;
   } sts_type;
endpackage
`default_nettype wire

// ----- hdl/kway_heap_merge.sv -----
// ---------------------------------------------------------------------------
// kway_heap_merge: k-way merge of sorted runs
// Holds run heads, emits the first row in key order on start, after each refill and on exhausted.
// ---------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                               | tuser
// req     | in  | run_index[3:0], key0..key3, row_tag             | operation[1:0]
// rsp     | out | out_run[3:0], out_key0..3, out_tag              | merge_done
// csr     | in  | 0x0 key_column_count, 0x4 ascending_mask        | -
//
// Start, next row and exhausted step through accept, then a store read and a
// compare per live entry, then end of scan, emit and fill; a load is only
// accepted, and a done result is loaded from its own state.
// Reset clears size, popped run, pending flag and config; store is not cleared.
// A finished row waits in the output register; the block stalls only when
// a new result is due while the previous one is still untaken.
// ---------------------------------------------------------------------------
`default_nettype none
module kway_heap_merge #(
   parameter int MAX_RUNS    = 16,
   parameter int KEY_COLUMNS = 4,
   parameter int KEY_WIDTH   = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // run_index, key_zero, key_one, key_two, key_three, row_tag
   input  wire logic [167:0] req_tdata,
   // operation
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_run, out_key_zero, out_key_one, out_key_two, out_key_three, out_tag
   output logic [167:0]      rsp_tdata,
   // merge_done
   output logic              rsp_tuser,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int KB = KEY_COLUMNS*KEY_WIDTH;

   logic [2:0]  cols_ff;
   logic [3:0]  asc_ff;
   logic        req_fire, rsp_free, csr_wr;
   logic [KB-1:0] in_keys, o_keys;
   logic [3:0]  o_run;
   logic [31:0] o_tag;
   logic        o_done;
   khm_pkg::cmd_type cmd;
   khm_pkg::sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 3'd1;
         asc_ff  <= 4'hf;
      end else if (csr_wr) begin
         if (csr_paddr[2] == 1'(khm_pkg::REG_COLS)) cols_ff <= csr_pwdata[2:0];
         else asc_ff <= csr_pwdata[3:0];
      end
   end
   // key count saturates at KEY_COLUMNS
   logic [2:0] cols_eff;
   assign cols_eff = (int'(cols_ff) > KEY_COLUMNS) ? 3'(KEY_COLUMNS) : cols_ff;
   assign csr_prdata = (csr_paddr[2] == 1'(khm_pkg::REG_ASC)) ? {28'd0, asc_ff}
                                                             : {29'd0, cols_ff};

   // fixed 32-bit key fields feed the parameterized key bus
   always_comb begin
      in_keys = '0;
      for (int c = 0; c < KEY_COLUMNS && c < 4; c++)
         in_keys[c*KEY_WIDTH +: KEY_WIDTH] = KEY_WIDTH'(req_tdata[4+32*c +: 32]);
   end

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid || rsp_tready;

   khm_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_op(req_tuser), .rsp_free, .sts,
      .req_ready(req_tready), .cmd
   );

   khm_dp #(.MAX_RUNS(MAX_RUNS), .KEY_COLUMNS(KEY_COLUMNS), .KEY_WIDTH(KEY_WIDTH)) u_dp (
      .clock, .reset, .cmd, .in_run(req_tdata[3:0]), .in_keys,
      .in_tag(req_tdata[163:132]), .cfg_cols(cols_eff), .cfg_asc(asc_ff),
      .rsp_take(rsp_tready), .sts, .rsp_valid(rsp_tvalid), .out_done(o_done),
      .out_run(o_run), .out_keys(o_keys), .out_tag(o_tag)
   );

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[3:0] = o_run;
      for (int c = 0; c < KEY_COLUMNS && c < 4; c++)
         rsp_tdata[4+32*c +: 32] = 32'(o_keys[c*KEY_WIDTH +: KEY_WIDTH]);
      rsp_tdata[163:132] = o_tag;
   end
   assign rsp_tuser = o_done;

   // a new result never overwrites an untaken one
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(cmd.emit || cmd.done)) else $error("clobber");
   // requests are only taken with no command in flight
   a_idle_take: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(cmd.emit || cmd.move || cmd.done)) else $error("busy take");
   // a done result carries zero payload
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0) else $error("done payload");
endmodule
`default_nettype wire

// ----- hdl/khm_ctrl.sv -----
// ---------------------------------------------------------------------------
// khm_ctrl: merge sequencer
// Decodes one request and steps the datapath through a load, a scan, emit and fill, or a done result.
// ---------------------------------------------------------------------------
`default_nettype none
module khm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_fire,
   input  wire logic [1:0]       req_op,
   input  wire logic             rsp_free,
   input  wire khm_pkg::sts_type sts,
   output logic                  req_ready,
   output khm_pkg::cmd_type      cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_MOVE  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               case (req_op)
                  khm_pkg::OP_LOAD: begin
                     if (!pend_ff && !sts.full) cmd.put = 1'b1;
                  end
                  khm_pkg::OP_START: begin
                     if (!pend_ff) begin
                        cmd.scan_init = 1'b1;
                        state_in = sts.empty ? S_DONE : S_FETCH;
                     end
                  end
                  khm_pkg::OP_NEXT: begin
                     if (pend_ff) begin
                        cmd.put     = !sts.full;
                        cmd.put_run = 1'b1;
                        cmd.scan_init = 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     if (pend_ff) begin
                        cmd.scan_init = 1'b1;
                        state_in = sts.empty ? S_DONE : S_FETCH;
                     end
                  end
               endcase
            end
         end
         S_FETCH: begin
            if (sts.scan_end) state_in = S_EMIT;
            else begin
               cmd.fetch = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.scan_step = 1'b1;
            state_in = S_FETCH;
         end
         S_EMIT: begin
            if (rsp_free) begin
               cmd.emit = 1'b1;
               pend_in  = 1'b1;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_IDLE;
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.done = 1'b1;
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/khm_dp.sv -----
// ---------------------------------------------------------------------------
// khm_dp: entry store, linear best search and result register
// Entries are read from the store one at a time, each fetched then compared; the best one is held in regs.
// ---------------------------------------------------------------------------
`default_nettype none
module khm_dp #(
   parameter int MAX_RUNS    = 16,
   parameter int KEY_COLUMNS = 4,
   parameter int KEY_WIDTH   = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire khm_pkg::cmd_type              cmd,
   input  wire logic [3:0]                    in_run,
   input  wire logic [KEY_COLUMNS*KEY_WIDTH-1:0] in_keys,
   input  wire logic [31:0]                   in_tag,
   input  wire logic [2:0]                    cfg_cols,
   input  wire logic [3:0]                    cfg_asc,
   input  wire logic                          rsp_take,
   output khm_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   output logic                               out_done,
   output logic [3:0]                         out_run,
   output logic [KEY_COLUMNS*KEY_WIDTH-1:0]   out_keys,
   output logic [31:0]                        out_tag
);
   localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
   localparam int SW = $clog2(MAX_RUNS + 1);
   localparam int EW = KEY_COLUMNS*KEY_WIDTH + 36;

   logic [EW-1:0] mem [MAX_RUNS];
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] idx_ff;
   logic [IW-1:0] bidx_ff;
   logic [EW-1:0] best_ff, cand_ff, rd_ff;
   logic          rv_ff;
   logic [3:0]    popped_ff;
   logic          better;

   // entry layout: {tag, run, keys}
   function automatic logic first(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                  input logic [2:0] cols, input logic [3:0] asc);
      logic decided, res;
      logic [KEY_WIDTH-1:0] x, y;
      decided = 1'b0;
      res     = 1'b0;
      for (int c = 0; c < KEY_COLUMNS; c++) begin
         x = a[c*KEY_WIDTH +: KEY_WIDTH];
         y = b[c*KEY_WIDTH +: KEY_WIDTH];
         if (!decided && (c < int'(cols)) && x != y) begin
            decided = 1'b1;
            res = ((c < 4) ? asc[c % 4] : 1'b1) ? (x < y) : (x > y);
         end
      end
      if (!decided && a[EW-33 -: 4] != b[EW-33 -: 4]) begin
         decided = 1'b1;
         res = a[EW-33 -: 4] < b[EW-33 -: 4];
      end
      for (int c = 0; c < KEY_COLUMNS; c++) begin
         x = a[c*KEY_WIDTH +: KEY_WIDTH];
         y = b[c*KEY_WIDTH +: KEY_WIDTH];
         if (!decided && x != y) begin
            decided = 1'b1;
            res = x < y;
         end
      end
      if (!decided) res = a[EW-1 -: 32] < b[EW-1 -: 32];
      return res;
   endfunction

   assign better       = first(cand_ff, best_ff, cfg_cols, cfg_asc);
   assign sts.full     = (size_ff == SW'(MAX_RUNS));
   assign sts.empty    = (size_ff == '0);
   assign sts.scan_end = (idx_ff >= size_ff);

   always_comb begin
      size_in = size_ff;
      if (cmd.put) size_in = size_ff + 1'b1;
      if (cmd.emit) size_in = size_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.put)
         mem[size_ff[IW-1:0]] <= {in_tag, cmd.put_run ? popped_ff : in_run, in_keys};
      if (cmd.move)
         mem[bidx_ff] <= rd_ff;
      rd_ff <= mem[cmd.emit ? size_in[IW-1:0] : idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) idx_ff <= '0;
      else if (cmd.fetch) idx_ff <= idx_ff + 1'b1;
      if (cmd.fetch) cand_ff <= mem[idx_ff[IW-1:0]];
      if (cmd.scan_step && (idx_ff == SW'(1) || better)) begin
         best_ff <= cand_ff;
         bidx_ff <= IW'(idx_ff - 1'b1);
      end
      if (cmd.emit) begin
         out_done <= 1'b0;
         out_run  <= best_ff[EW-33 -: 4];
         out_keys <= best_ff[KEY_COLUMNS*KEY_WIDTH-1:0];
         out_tag  <= best_ff[EW-1 -: 32];
      end else if (cmd.done) begin
         out_done <= 1'b1;
         out_run  <= '0;
         out_keys <= '0;
         out_tag  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= '0;
         popped_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         size_ff <= size_in;
         if (cmd.emit) popped_ff <= best_ff[EW-33 -: 4];
         if (cmd.emit || cmd.done) rv_ff <= 1'b1;
         else if (rsp_take) rv_ff <= 1'b0;
      end
   end

   assign rsp_valid = rv_ff;
endmodule
`default_nettype wire

// ----- test/kway_heap_merge_test.sv -----
// ---------------------------------------------------------------------------
// kway_heap_merge_test: self-checking bench for the k-way heap merge
// Drives load/start/next/exhausted requests, predicts each emitted row or
// done flag with a behavioral merge set, and compares results in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module kway_heap_merge_test;
   localparam int NRUNS = 16;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] k3;
      logic [31:0] k2;
      logic [31:0] k1;
      logic [31:0] k0;
      logic [3:0]  run;
   } row_type;

   typedef struct packed {
      logic    done;
      row_type row;
   } merge_out_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [167:0] req_tdata = '0;   // run_index, key0..key3, row_tag
   logic [1:0] req_tuser = '0;     // operation
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [167:0] rsp_tdata;        // out_run, out_key0..3, out_tag
   logic rsp_tuser;                // merge_done
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   kway_heap_merge dut (.*);

   always #6 clock = ~clock;

   // predictor state
   row_type     set_rows[NRUNS];
   int          set_count;
   logic [3:0]  last_run;
   logic        awaiting_refill;
   logic [2:0]  cols_cfg;
   logic [3:0]  asc_cfg;
   merge_out_type expected_q[$];

   int  mismatches = 0;
   bit  calm = 0;          // no idling in the last part
   int  idle_cycles = 0;
   int  items_sent = 0;

   // a leaves before b
   function automatic bit row_first(row_type a, row_type b);
      logic [31:0] ka[4], kb[4];
      int n;
      ka = '{a.k0, a.k1, a.k2, a.k3};
      kb = '{b.k0, b.k1, b.k2, b.k3};
      n = (cols_cfg > 4) ? 4 : cols_cfg;
      for (int c = 0; c < n; c++)
         if (ka[c] != kb[c]) return asc_cfg[c] ? (ka[c] < kb[c]) : (ka[c] > kb[c]);
      if (a.run != b.run) return a.run < b.run;
      for (int c = 0; c < 4; c++)
         if (ka[c] != kb[c]) return ka[c] < kb[c];
      return a.tag < b.tag;
   endfunction

   function automatic void pop_smallest();
      merge_out_type r;
      int best;
      r = '0;
      if (set_count == 0) begin
         r.done = 1;
         awaiting_refill = 0;
      end else begin
         best = 0;
         for (int i = 1; i < set_count; i++)
            if (row_first(set_rows[i], set_rows[best])) best = i;
         r.row = set_rows[best];
         last_run = set_rows[best].run;
         set_count--;
         set_rows[best] = set_rows[set_count];
         awaiting_refill = 1;
      end
      expected_q = {expected_q, r};
   endfunction

   function automatic void predict_merge(logic [1:0] op, row_type row);
      case (op)
         khm_pkg::OP_LOAD: if (!awaiting_refill && set_count < NRUNS) begin
            set_rows[set_count] = row;
            set_count++;
         end
         khm_pkg::OP_START: if (!awaiting_refill) pop_smallest();
         khm_pkg::OP_NEXT: if (awaiting_refill) begin
            if (set_count < NRUNS) begin
               row.run = last_run;
               set_rows[set_count] = row;
               set_count++;
            end
            pop_smallest();
         end
         default: if (awaiting_refill) pop_smallest();
      endcase
   endfunction

   // valid stays high between back-to-back requests unless a random idle gap is drawn; drain() drops it
   task automatic send_request(logic [1:0] op, row_type row);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {4'd0, row};
      do @(posedge clock); while (!req_tready);
      predict_merge(op, row);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(int idx, logic [31:0] value);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 3'(4 * idx); csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(negedge clock);
      if (idx == khm_pkg::REG_COLS) cols_cfg = value[2:0];
      else asc_cfg = value[3:0];
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_config(logic [2:0] cols, logic [3:0] asc);
      drain();
      write_csr(khm_pkg::REG_COLS, cols);
      write_csr(khm_pkg::REG_ASC, asc);
   endtask

   function automatic row_type random_row(int kspan);
      row_type r;
      r.run = 4'($urandom);
      r.k0 = kspan ? $urandom_range(0, kspan) : $urandom;
      r.k1 = kspan ? $urandom_range(0, kspan) : $urandom;
      r.k2 = kspan ? $urandom_range(0, kspan) : $urandom;
      r.k3 = kspan ? $urandom_range(0, kspan) : $urandom;
      r.tag = $urandom;
      return r;
   endfunction

   // one full merge: load heads, start, then refill or exhaust each popped run, with random noise
   task automatic merge_session(int runs, int depth, int kspan);
      int left;
      row_type r;
      for (int i = 0; i < runs; i++) begin
         r = random_row(kspan);
         r.run = 4'(i);
         send_request(khm_pkg::OP_LOAD, r);
      end
      send_request(khm_pkg::OP_START, random_row(kspan));
      left = runs * depth;
      while (awaiting_refill) begin
         if ($urandom_range(0, 19) == 0)
            send_request(2'($urandom), random_row(kspan));   // noise
         else if (left > 0 && $urandom_range(0, 3) != 0) begin
            left--;
            send_request(khm_pkg::OP_NEXT, random_row(kspan));
         end else
            send_request(khm_pkg::OP_EXH, random_row(kspan));
      end
   endtask

   task automatic test_directed();
      row_type r;
      r = '1;
      send_request(khm_pkg::OP_START, r);   // empty set gives done
      send_request(khm_pkg::OP_NEXT, r);    // ignored, nothing pending
      send_request(khm_pkg::OP_EXH, r);     // ignored
      send_request(khm_pkg::OP_LOAD, r);
      r = '0;
      send_request(khm_pkg::OP_LOAD, r);
      send_request(khm_pkg::OP_START, r);
      send_request(khm_pkg::OP_LOAD, r);    // ignored, refill pending
      send_request(khm_pkg::OP_START, r);   // ignored, refill pending
      send_request(khm_pkg::OP_NEXT, '1);
      send_request(khm_pkg::OP_EXH, r);
      send_request(khm_pkg::OP_EXH, r);
      send_request(khm_pkg::OP_EXH, r);     // ignored, nothing pending
      for (int i = 0; i < 17; i++) begin    // last load hits a full set
         r = random_row(3);
         send_request(khm_pkg::OP_LOAD, r);
      end
      send_request(khm_pkg::OP_START, r);
      send_request(khm_pkg::OP_NEXT, r);    // refill of the popped run
      while (awaiting_refill) send_request(khm_pkg::OP_EXH, r);
   endtask

   task automatic test_column_settings();
      logic [2:0] cl[6] = '{3'd0, 3'd1, 3'd4, 3'd7, 3'd2, 3'd3};
      logic [3:0] ml[6] = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd5, 4'd10};
      for (int s = 0; s < 6; s++) begin
         set_config(cl[s], ml[s]);
         repeat (4) merge_session($urandom_range(1, 16), 2, 3);
      end
   endtask

   task automatic test_random();
      while (items_sent < 1750) begin
         if (items_sent > 1500) calm = 1;
         if ($urandom_range(0, 9) == 0) begin
            set_config(3'($urandom), 4'($urandom));
         end
         merge_session($urandom_range(1, 16), $urandom_range(0, 3),
                       $urandom_range(0, 1) ? 3 : 0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      merge_out_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got.done = rsp_tuser;
         got.row = rsp_tdata[163:0];
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (!calm && $urandom_range(0, 5) == 0) rsp_tready <= 0;
      else rsp_tready <= 1;
   end

   // watchdog on accepted handshakes and csr accesses
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      set_count = 0;
      last_run = 0;
      awaiting_refill = 0;
      cols_cfg = 1;
      asc_cfg = 4'hF;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_column_settings();
      test_random();
      drain();
      if (mismatches == 0 && expected_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/khm_pkg.sv
hdl/khm_ctrl.sv
hdl/khm_dp.sv
hdl/kway_heap_merge.sv
test/kway_heap_merge_test.sv
